// ----- hdl/md4sh_pkg.sv -----
// ----------------------------------------------------------------------------
// md4sh_pkg
// Types, constants and the control store of the MD4 stream hasher sequencer.
// ----------------------------------------------------------------------------
package md4sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [31:0] K_G    = 32'h5a827999;
    localparam logic [31:0] K_H    = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    localparam logic [4:0] SH1 [4] = '{5'd3, 5'd7, 5'd11, 5'd19};
    localparam logic [4:0] SH2 [4] = '{5'd3, 5'd5, 5'd9,  5'd13};
    localparam logic [4:0] SH3 [4] = '{5'd3, 5'd9, 5'd11, 5'd15};
    localparam logic [3:0] ORD3 [16] = '{4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
                                         4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15};

    // micro-operations
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_ROUND = 3'd2;
    localparam logic [2:0] OP_FOLD  = 3'd3;
    localparam logic [2:0] OP_PAD   = 3'd4;
    localparam logic [2:0] OP_LEN   = 3'd5;
    localparam logic [2:0] OP_ZERO  = 3'd6;
    localparam logic [2:0] OP_OUT   = 3'd7;

    // sequencing
    localparam logic [2:0] NX_SEQ    = 3'd0;
    localparam logic [2:0] NX_JUMP   = 3'd1;
    localparam logic [2:0] NX_PHASE  = 3'd2;
    localparam logic [2:0] NX_PADCHK = 3'd3;
    localparam logic [2:0] NX_HALT   = 3'd4;

    // round functions
    localparam logic [1:0] FN_F = 2'd0;
    localparam logic [1:0] FN_G = 2'd1;
    localparam logic [1:0] FN_H = 2'd2;

    // block phases
    localparam logic [1:0] PH_DATA  = 2'd0;
    localparam logic [1:0] PH_PAD   = 2'd1;
    localparam logic [1:0] PH_EXTRA = 2'd2;
    localparam logic [1:0] PH_FINAL = 2'd3;

    // program layout
    localparam logic [5:0] STEP_LOAD  = 6'd0;
    localparam logic [5:0] STEP_RND0  = 6'd1;
    localparam logic [5:0] STEP_RNDN  = 6'd48;
    localparam logic [5:0] STEP_FOLD  = 6'd49;
    localparam logic [5:0] STEP_PAD   = 6'd50;
    localparam logic [5:0] STEP_LEN   = 6'd51;
    localparam logic [5:0] STEP_ZERO  = 6'd52;
    localparam logic [5:0] STEP_OUT0  = 6'd53;
    localparam logic [5:0] STEP_OUT1  = 6'd54;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] msg;
        logic [4:0] rot;
        logic [1:0] fn;
        logic [2:0] nxt;
        logic [5:0] target;
        logic       last;
    } t_uword;

    function automatic t_uword uword(input logic [5:0] pc);
        t_uword     w;
        logic [5:0] i;
        logic [3:0] j;
        w = '{op: OP_NOP, msg: 4'd0, rot: 5'd0, fn: FN_F, nxt: NX_SEQ,
              target: STEP_LOAD, last: 1'b0};
        i = pc - STEP_RND0;
        j = i[3:0];
        if (pc >= STEP_RND0 && pc <= STEP_RNDN) begin
            w.op = OP_ROUND;
            priority if (i[5:4] == FN_F) begin
                w.fn  = FN_F;
                w.msg = j;
                w.rot = SH1[j[1:0]];
            end else if (i[5:4] == FN_G) begin
                w.fn  = FN_G;
                w.msg = {j[1:0], j[3:2]};
                w.rot = SH2[j[1:0]];
            end else begin
                w.fn  = FN_H;
                w.msg = ORD3[j];
                w.rot = SH3[j[1:0]];
            end
        end else begin
            unique case (pc)
                STEP_LOAD: w.op = OP_LOAD;
                STEP_FOLD: begin
                    w.op  = OP_FOLD;
                    w.nxt = NX_PHASE;
                end
                STEP_PAD: begin
                    w.op  = OP_PAD;
                    w.nxt = NX_PADCHK;
                end
                STEP_LEN: begin
                    w.op  = OP_LEN;
                    w.nxt = NX_JUMP;
                end
                STEP_ZERO: begin
                    w.op     = OP_ZERO;
                    w.nxt    = NX_JUMP;
                    w.target = STEP_LEN;
                end
                STEP_OUT0: w.op = OP_OUT;
                STEP_OUT1: begin
                    w.op   = OP_OUT;
                    w.nxt  = NX_HALT;
                    w.last = 1'b1;
                end
                default: w.nxt = NX_HALT;
            endcase
        end
        return w;
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

endpackage

// ----- hdl/md4_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// md4_stream_hasher
// MD4 digest of a byte stream, run by a microcoded round sequencer.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the sequencer is idle. The 64th byte of
// a block holds o_stall high through load, 48 rounds through the one round
// adder and the fold into the chaining words. A closing item runs pad,
// length, compression and two digest words; a padding spill into an extra
// block adds a compression and a zeroed block ahead of the length; a byte
// that closes and completes a block adds its compression first. Digest words
// leave through an output register; output steps wait while it is stalled.
module md4_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic        o_word_index,
    output logic        o_last_word
);
    import md4sh_pkg::*;

    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_buf   [16];
    logic [31:0] n_buf   [16];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_count, n_count;
    logic [5:0]  r_pc, n_pc;
    logic [1:0]  r_phase, n_phase;
    logic        r_busy, n_busy;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_word, n_out_word;
    logic        r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last;

    t_uword      uw;
    logic        in_xfer;
    logic        out_free;
    logic [31:0] fval, kc, rsum;
    logic [5:0]  bpos;

    assign uw       = uword(r_pc);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        unique case (uw.fn)
            FN_F:    fval = (r_b & r_c) | (~r_b & r_d);
            FN_G:    fval = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default: fval = r_b ^ r_c ^ r_d;
        endcase
        unique case (uw.fn)
            FN_F:    kc = 32'd0;
            FN_G:    kc = K_G;
            default: kc = K_H;
        endcase
        rsum = r_a + fval + r_buf[uw.msg] + kc;
    end

    always_comb begin
        n_chain     = r_chain;
        n_buf       = r_buf;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_fill      = r_fill;
        n_count     = r_count;
        n_pc        = r_pc;
        n_phase     = r_phase;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_stall;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        bpos        = 6'd0;

        if (!r_busy) begin
            if (in_xfer) begin
                if (i_byte_valid) begin
                    n_buf[r_fill[5:2]][8*r_fill[1:0] +: 8] = i_data_byte;
                    n_count = r_count + 61'd1;
                    n_fill  = r_fill + 6'd1;
                end
                if (i_byte_valid && r_fill == 6'd63) begin
                    n_busy  = 1'b1;
                    n_pc    = STEP_LOAD;
                    n_phase = i_end_of_message ? PH_PAD : PH_DATA;
                end else if (i_end_of_message) begin
                    n_busy  = 1'b1;
                    n_pc    = STEP_PAD;
                    n_phase = PH_PAD;
                end
            end
        end else if (uw.op != OP_OUT || out_free) begin
            unique case (uw.op)
                OP_LOAD: begin
                    n_a = r_chain[0];
                    n_b = r_chain[1];
                    n_c = r_chain[2];
                    n_d = r_chain[3];
                end
                OP_ROUND: begin
                    n_a = r_d;
                    n_d = r_c;
                    n_c = r_b;
                    n_b = rol32(rsum, uw.rot);
                end
                OP_FOLD: begin
                    n_chain[0] = r_chain[0] + r_a;
                    n_chain[1] = r_chain[1] + r_b;
                    n_chain[2] = r_chain[2] + r_c;
                    n_chain[3] = r_chain[3] + r_d;
                end
                OP_PAD: begin
                    for (int w = 0; w < 16; w++) begin
                        for (int k = 0; k < 4; k++) begin
                            bpos = {w[3:0], k[1:0]};
                            if (bpos == r_fill) begin
                                n_buf[w][8*k +: 8] = PAD_BYTE;
                            end else if (bpos > r_fill) begin
                                n_buf[w][8*k +: 8] = 8'd0;
                            end
                        end
                    end
                end
                OP_LEN: begin
                    n_buf[14] = {r_count[28:0], 3'b000};
                    n_buf[15] = r_count[60:29];
                    n_phase   = PH_FINAL;
                end
                OP_ZERO: begin
                    for (int w = 0; w < 16; w++) begin
                        n_buf[w] = 32'd0;
                    end
                end
                OP_OUT: begin
                    n_out_valid = 1'b1;
                    n_out_idx   = uw.last;
                    n_out_last  = uw.last;
                    n_out_word  = uw.last ? {r_chain[3], r_chain[2]}
                                          : {r_chain[1], r_chain[0]};
                    if (uw.last) begin
                        n_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
                        n_fill  = 6'd0;
                        n_count = 61'd0;
                        n_phase = PH_DATA;
                    end
                end
                default: ;
            endcase

            unique case (uw.nxt)
                NX_SEQ:  n_pc = r_pc + 6'd1;
                NX_JUMP: n_pc = uw.target;
                NX_PHASE: begin
                    unique case (r_phase)
                        PH_DATA: begin
                            n_busy = 1'b0;
                            n_pc   = STEP_LOAD;
                        end
                        PH_PAD:   n_pc = STEP_PAD;
                        PH_EXTRA: n_pc = STEP_ZERO;
                        default:  n_pc = STEP_OUT0;
                    endcase
                end
                NX_PADCHK: begin
                    if (r_fill >= LEN_POS) begin
                        n_phase = PH_EXTRA;
                        n_pc    = uw.target;
                    end else begin
                        n_pc = r_pc + 6'd1;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_pc   = STEP_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_chain     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
            r_fill      <= 6'd0;
            r_count     <= 61'd0;
            r_pc        <= STEP_LOAD;
            r_phase     <= PH_DATA;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chain     <= n_chain;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_pc        <= n_pc;
            r_phase     <= n_phase;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

`ifndef SYNTHESIS
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_phase == PH_DATA)
        else $error("idle with a pending block phase");

    a_round_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && uw.op == OP_ROUND) |=> r_busy)
        else $error("sequencer halted inside the rounds");

    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_byte_valid && r_fill == 6'd63) |=>
            (r_busy && r_pc == STEP_LOAD && r_fill == 6'd0))
        else $error("full block did not start compression");

    a_digest_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_pc == STEP_OUT1 && out_free) |=>
            (!r_busy && r_fill == 6'd0 && r_count == 61'd0 && r_chain[0] == INIT_A))
        else $error("state not restored after digest");
`endif

endmodule
